// ===== design/tbl_pkg.sv =====
// shared types and codes for the token bucket limiter
`default_nettype none

package tbl_pkg;

	// request modes as they arrive on the input word
	localparam logic [1:0] MODE_TRY     = 2'd0;
	localparam logic [1:0] MODE_ACQUIRE = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W        = 1;
	localparam logic [0:0] CFG_TOKEN_RATE   = 1'b0;
	localparam logic [0:0] CFG_BUCKET_DEPTH = 1'b1;

	// widths of the fixed fields
	localparam int PERMIT_W = 16;
	localparam int TICK_W   = 16;
	localparam int RATE_W   = 32;
	localparam int DEPTH_W  = 16;
	localparam int LEVEL_W  = 32;
	localparam int INC_W    = TICK_W + RATE_W;
	localparam int WIDE_W   = 48;

	// request class decided by the front end
	typedef enum logic [1:0] {
		CLS_TRY     = 2'd0,
		CLS_ACQUIRE = 2'd1,
		CLS_QUERY   = 2'd2
	} cls_t;

	localparam int CLS_W = 2;

	typedef struct packed {
		logic [1:0]          mode;
		logic [PERMIT_W-1:0] permits;
		logic [TICK_W-1:0]   elapsed_ticks;
	} req_t;

	typedef struct packed {
		logic               granted;
		logic [LEVEL_W-1:0] tokens_left;
		logic [LEVEL_W-1:0] wait_ticks;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/tbl_fifo.sv =====
// small register queue between the front end and the back end
`default_nettype none

module tbl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== design/tbl_front.sv =====
// front end: takes request words, classifies them and works out the refill
`default_nettype none

module tbl_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire tbl_pkg::req_t                 in_word,
	input  wire logic [tbl_pkg::RATE_W-1:0]    rate_eff,
	output logic                               push,
	output logic [tbl_pkg::CLS_W+tbl_pkg::PERMIT_W+FRAC_BITS+tbl_pkg::INC_W-1:0] push_data,
	input  wire logic                          fifo_full
);

	localparam int NEED_W = tbl_pkg::PERMIT_W + FRAC_BITS;

	tbl_pkg::req_t req_s1;
	logic          valid_s1;
	logic          take;

	tbl_pkg::cls_t                cls;
	logic [NEED_W-1:0]            need;
	logic [tbl_pkg::INC_W-1:0]    inc;

	assign in_stall = valid_s1 && fifo_full;
	assign take     = in_valid && !in_stall;
	assign push     = valid_s1 && !fifo_full;

	always_comb begin
		unique case (req_s1.mode)
			tbl_pkg::MODE_TRY:     cls = tbl_pkg::CLS_TRY;
			tbl_pkg::MODE_ACQUIRE: cls = tbl_pkg::CLS_ACQUIRE;
			default:               cls = tbl_pkg::CLS_QUERY;
		endcase
	end

	// permits in token units, and tokens gained since the last word
	assign need = NEED_W'(req_s1.permits) << FRAC_BITS;
	assign inc  = tbl_pkg::INC_W'(req_s1.elapsed_ticks) * tbl_pkg::INC_W'(rate_eff);

	assign push_data = {cls, need, inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= in_word;
		end
	end

endmodule

`default_nettype wire

// ===== design/tbl_divider.sv =====
// bit-serial restoring divider for the wait estimate
`default_nettype none

module tbl_divider #(
	parameter int DIV_W = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DIV_W-1:0]           dividend,
	input  wire logic [tbl_pkg::RATE_W-1:0] divisor,
	output logic                            done,
	output logic [DIV_W-1:0]                quotient
);

	localparam int RW = tbl_pkg::RATE_W;
	localparam int CW = $clog2(DIV_W + 1);

	logic [RW-1:0]    rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [RW-1:0]    dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [RW:0]      trial;
	logic [RW:0]      diff;
	logic             ge;

	// shift one dividend bit into the partial remainder per cycle
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIV_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== design/tbl_back.sv =====
// back end: refill, admission decision, bucket state and result register
`default_nettype none

module tbl_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           ent_valid,
	input  wire logic [tbl_pkg::CLS_W+tbl_pkg::PERMIT_W+FRAC_BITS+tbl_pkg::INC_W-1:0] ent_data,
	output logic                                pop,
	input  wire logic [tbl_pkg::RATE_W-1:0]     rate_eff,
	input  wire logic [tbl_pkg::LEVEL_W-1:0]    cap,
	input  wire logic                           fill,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tbl_pkg::rsp_t                       out_word
);

	localparam int NEED_W = tbl_pkg::PERMIT_W + FRAC_BITS;
	localparam int ENT_W  = tbl_pkg::CLS_W + NEED_W + tbl_pkg::INC_W;
	localparam int LW     = tbl_pkg::LEVEL_W;
	localparam int WW     = tbl_pkg::WIDE_W;
	localparam logic [LW-1:0] LEVEL_RESET = LW'(1) << FRAC_BITS;
	localparam logic [WW-1:0] MAX32       = WW'(32'hFFFF_FFFF);

	typedef enum logic [1:0] {
		ST_REFILL,
		ST_DECIDE,
		ST_DIV
	} state_t;

	state_t                 state_q;
	logic [LW-1:0]          bucket_level_q;
	tbl_pkg::rsp_t          out_word_q;
	logic                   out_valid_q;
	tbl_pkg::cls_t          cls_s1;
	logic [NEED_W-1:0]      need_s1;
	logic [LW-1:0]          lvl_s1;

	tbl_pkg::cls_t             head_cls;
	logic [NEED_W-1:0]         head_need;
	logic [tbl_pkg::INC_W-1:0] head_inc;
	logic [tbl_pkg::INC_W:0]   sum;
	logic [LW-1:0]             capped;

	logic [WW-1:0]     need_w;
	logic [WW-1:0]     lvl_w;
	logic [WW-1:0]     deficit_w;
	logic              covers;
	logic              is_take;
	logic              grant;
	logic              deny_wait;
	logic [LW-1:0]     left;
	logic              out_free;

	logic              div_start;
	logic              div_done;
	logic [NEED_W-1:0] div_quo;
	logic [WW-1:0]     wait_w;
	logic [LW-1:0]     wait_sat;

	assign head_cls  = tbl_pkg::cls_t'(ent_data[ENT_W-1 -: tbl_pkg::CLS_W]);
	assign head_need = ent_data[tbl_pkg::INC_W +: NEED_W];
	assign head_inc  = ent_data[tbl_pkg::INC_W-1:0];

	// refill and clip at the burst cap
	assign sum    = (tbl_pkg::INC_W + 1)'(bucket_level_q) + (tbl_pkg::INC_W + 1)'(head_inc);
	assign capped = (sum > (tbl_pkg::INC_W + 1)'(cap)) ? cap : sum[LW-1:0];

	assign need_w    = WW'(need_s1);
	assign lvl_w     = WW'(lvl_s1);
	assign covers    = (lvl_w >= need_w);
	assign deficit_w = need_w - lvl_w;
	assign left      = lvl_s1 - need_w[LW-1:0];
	assign is_take   = (cls_s1 == tbl_pkg::CLS_TRY) || (cls_s1 == tbl_pkg::CLS_ACQUIRE);
	assign grant     = is_take && covers;
	assign deny_wait = (cls_s1 == tbl_pkg::CLS_ACQUIRE) && !covers;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_REFILL) && ent_valid;
	assign div_start = (state_q == ST_DECIDE) && deny_wait;

	assign wait_w   = WW'(div_quo) + WW'(1);
	assign wait_sat = (wait_w > MAX32) ? '1 : wait_w[LW-1:0];

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	tbl_divider #(
		.DIV_W(NEED_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(deficit_w[NEED_W-1:0]),
		.divisor (rate_eff),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_REFILL;
			bucket_level_q <= LEVEL_RESET;
			out_valid_q    <= 1'b0;
			out_word_q     <= '0;
			cls_s1         <= tbl_pkg::CLS_QUERY;
			need_s1        <= '0;
			lvl_s1         <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fill) begin
				bucket_level_q <= cap;
			end
			unique case (state_q)
				ST_REFILL: begin
					if (ent_valid) begin
						cls_s1  <= head_cls;
						need_s1 <= head_need;
						lvl_s1  <= capped;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (deny_wait) begin
						bucket_level_q <= lvl_s1;
						state_q        <= ST_DIV;
					end else if (out_free) begin
						bucket_level_q         <= grant ? left : lvl_s1;
						out_word_q.granted     <= grant;
						out_word_q.tokens_left <= grant ? left : lvl_s1;
						out_word_q.wait_ticks  <= '0;
						out_valid_q            <= 1'b1;
						state_q                <= ST_REFILL;
					end
				end
				ST_DIV: begin
					if (div_done && out_free) begin
						out_word_q.granted     <= 1'b0;
						out_word_q.tokens_left <= lvl_s1;
						out_word_q.wait_ticks  <= wait_sat;
						out_valid_q            <= 1'b1;
						state_q                <= ST_REFILL;
					end
				end
				default: begin
					state_q <= ST_REFILL;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/token_bucket_limiter.sv =====
// top level of the token bucket admission limiter
//
// channel   direction  handshake                   word
// in        to block   in_valid / in_stall         tbl_pkg::req_t (mode, permits, elapsed)
// out       from block out_valid / out_stall       tbl_pkg::rsp_t (granted, level, wait)
// cfg       to block   cfg_we, cfg_index           cfg_wdata, no read-back
//
// a try, query or granted acquire goes through the back end loop
// (refill-and-cap state, then decide-and-update state); the front end
// registers each word ahead of it and keeps taking words into its queue
// a denied acquire also runs the bit-serial wait divider
// reset leaves the bucket full at one permit with a rate of one token per tick
// a stalled result holds the back end; the front end and queue still fill
`default_nettype none

module token_bucket_limiter #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire tbl_pkg::req_t                   in_word,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output tbl_pkg::rsp_t                        out_word,
	input  wire logic                            cfg_we,
	input  wire logic [tbl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tbl_pkg::RATE_W-1:0]      cfg_wdata
);

	localparam int NEED_W = tbl_pkg::PERMIT_W + FRAC_BITS;
	localparam int ENT_W  = tbl_pkg::CLS_W + NEED_W + tbl_pkg::INC_W;
	localparam int CAP_W  = tbl_pkg::DEPTH_W + FRAC_BITS;
	localparam int WW     = tbl_pkg::WIDE_W;
	localparam logic [tbl_pkg::RATE_W-1:0] RATE_ONE = tbl_pkg::RATE_W'(1) << FRAC_BITS;
	localparam logic [WW-1:0]              MAX32    = WW'(32'hFFFF_FFFF);

	// configuration registers
	logic [tbl_pkg::RATE_W-1:0]  rate_q;
	logic [tbl_pkg::DEPTH_W-1:0] depth_q;
	logic                        fill_q;

	logic [tbl_pkg::RATE_W-1:0]  rate_eff;
	logic [tbl_pkg::DEPTH_W-1:0] depth_eff;
	logic [CAP_W-1:0]            cap_full;
	logic [WW-1:0]               cap_w;
	logic [tbl_pkg::LEVEL_W-1:0] cap;

	// queue between front and back
	logic             push;
	logic [ENT_W-1:0] push_data;
	logic             fifo_full;
	logic             fifo_empty;
	logic             pop;
	logic [ENT_W-1:0] head_data;

	// a zero rate counts as one token per tick, a zero depth as one permit
	assign rate_eff  = (rate_q == '0) ? RATE_ONE : rate_q;
	assign depth_eff = (depth_q == '0) ? tbl_pkg::DEPTH_W'(1) : depth_q;

	// burst cap in token units, clipped to the level width
	assign cap_full = CAP_W'(depth_eff) << FRAC_BITS;
	assign cap_w    = WW'(cap_full);
	assign cap      = (cap_w > MAX32) ? '1 : cap_w[tbl_pkg::LEVEL_W-1:0];

	// a depth write refills the bucket from the new cap in the next cycle, unless a decide wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= RATE_ONE;
			depth_q <= tbl_pkg::DEPTH_W'(1);
			fill_q  <= 1'b0;
		end else begin
			fill_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					tbl_pkg::CFG_TOKEN_RATE: begin
						rate_q <= cfg_wdata;
					end
					tbl_pkg::CFG_BUCKET_DEPTH: begin
						depth_q <= cfg_wdata[tbl_pkg::DEPTH_W-1:0];
						fill_q  <= 1'b1;
					end
					default: begin
						fill_q <= 1'b0;
					end
				endcase
			end
		end
	end

	tbl_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.rate_eff (rate_eff),
		.push     (push),
		.push_data(push_data),
		.fifo_full(fifo_full)
	);

	tbl_fifo #(
		.WIDTH(ENT_W),
		.DEPTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_data),
		.pop   (pop),
		.rdata (head_data),
		.full  (fifo_full),
		.empty (fifo_empty)
	);

	tbl_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ent_valid(!fifo_empty),
		.ent_data (head_data),
		.pop      (pop),
		.rate_eff (rate_eff),
		.cap      (cap),
		.fill     (fill_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

`default_nettype wire

// ===== design/tbl_checker.sv =====
// port-level checks for the token bucket limiter, bound to the top level
`default_nettype none

module tbl_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire tbl_pkg::rsp_t out_word
);

	// a waiting result word is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// a grant never carries a wait estimate
	a_grant_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.granted |-> out_word.wait_ticks == '0)
		else $error("granted word with nonzero wait");

	// no result word right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind token_bucket_limiter tbl_checker u_tbl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the token bucket limiter with its own bucket model
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int PERIOD = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 12;
	localparam int WORDS_PER_PHASE = 75;
	localparam int TAIL_CYCLES = 64;
	localparam int REPORT_MAX = 10;

	// the package leaves code 3 unnamed; the block treats it as a query
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_LONG
	} stall_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	tbl_pkg::req_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tbl_pkg::rsp_t out_word;
	logic cfg_we = 1'b0;
	logic [tbl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tbl_pkg::RATE_W-1:0] cfg_wdata = '0;

	// bucket model: registers and level as they stand after reset
	logic [tbl_pkg::RATE_W-1:0] rate_q = tbl_pkg::RATE_W'(1) << FRAC;
	logic [tbl_pkg::DEPTH_W-1:0] depth_q = tbl_pkg::DEPTH_W'(1);
	logic [tbl_pkg::LEVEL_W-1:0] level_q = tbl_pkg::LEVEL_W'(1) << FRAC;

	tbl_pkg::req_t req_backlog[$];
	tbl_pkg::rsp_t due_responses[$];

	// sender burst shaping and receiver stall pattern, set per phase
	int unsigned gap_max = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	stall_style_t stall_style = STALL_NONE;
	int unsigned stall_left = 0;
	int unsigned stall_tick = 0;

	int n_words = 0;
	int n_checked = 0;
	int n_grants = 0;
	int n_waits = 0;
	int n_writes = 0;
	int n_phases = 0;
	int n_fail = 0;
	int unsigned cycles = 0;

	token_bucket_limiter #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	// burst cap in fixed point; a zero depth counts as one permit
	function automatic logic [63:0] bucket_cap();
		logic [63:0] whole;
		whole = (depth_q == '0) ? 64'd1 : 64'(depth_q);
		whole = whole << FRAC;
		return (whole > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : whole;
	endfunction

	// refill, cap, then take or deny; updates the model level
	function automatic tbl_pkg::rsp_t bucket_admit(tbl_pkg::req_t r);
		logic [63:0] rate;
		logic [63:0] cap;
		logic [63:0] level;
		logic [63:0] need;
		logic [63:0] ticks;
		tbl_pkg::rsp_t o;
		rate = (rate_q == '0) ? (64'd1 << FRAC) : 64'(rate_q);
		cap = bucket_cap();
		// every mode refills first, a query too
		level = 64'(level_q) + 64'(r.elapsed_ticks) * rate;
		if (level > cap)
			level = cap;
		o = '0;
		if (r.mode == tbl_pkg::MODE_TRY || r.mode == tbl_pkg::MODE_ACQUIRE) begin
			need = 64'(r.permits) << FRAC;
			if (need == 64'd0) begin
				o.granted = 1'b1;
			end else if (level >= need) begin
				level = level - need;
				o.granted = 1'b1;
			end else if (r.mode == tbl_pkg::MODE_ACQUIRE) begin
				// a request above the cap still gets the formula wait
				ticks = (need - level) / rate + 64'd1;
				o.wait_ticks = (ticks > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ticks[31:0];
			end
		end
		level_q = level[tbl_pkg::LEVEL_W-1:0];
		o.tokens_left = level[tbl_pkg::LEVEL_W-1:0];
		return o;
	endfunction

	// mostly requests near the bucket size so grants and denials both happen
	function automatic tbl_pkg::req_t random_request(int unsigned depth_eff);
		tbl_pkg::req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			r.mode = tbl_pkg::MODE_TRY;
		else if (pick < 16)
			r.mode = tbl_pkg::MODE_ACQUIRE;
		else if (pick < 19)
			r.mode = tbl_pkg::MODE_QUERY;
		else
			r.mode = MODE_SPARE;
		case ($urandom_range(0, 9))
			0: r.permits = '0;
			1: r.permits = 16'($urandom);
			2: r.permits = 16'(depth_eff + $urandom_range(1, 4));
			3, 4: begin
				r.permits = 16'($urandom_range(1, (depth_eff < 8) ? depth_eff : 8));
			end
			default: r.permits = 16'($urandom_range(1, depth_eff));
		endcase
		pick = $urandom_range(0, 9);
		if (pick < 3)
			r.elapsed_ticks = '0;
		else if (pick < 8)
			r.elapsed_ticks = 16'($urandom_range(1, 4));
		else if (pick < 9)
			r.elapsed_ticks = 16'($urandom_range(5, 300));
		else
			r.elapsed_ticks = 16'($urandom);
		return r;
	endfunction

	task automatic queue_req(logic [1:0] m, logic [tbl_pkg::PERMIT_W-1:0] p,
			logic [tbl_pkg::TICK_W-1:0] e);
		tbl_pkg::req_t r;
		r.mode = m;
		r.permits = p;
		r.elapsed_ticks = e;
		req_backlog.push_back(r);
	endtask

	// one register write; the model follows at the edge that takes it
	task automatic write_reg(logic [tbl_pkg::CFG_IDX_W-1:0] idx,
			logic [tbl_pkg::RATE_W-1:0] val);
		logic [63:0] full;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_writes++;
		if (idx == tbl_pkg::CFG_TOKEN_RATE) begin
			// level stays where it is
			rate_q = val;
		end else begin
			// a depth write fills the bucket to the new cap
			depth_q = val[tbl_pkg::DEPTH_W-1:0];
			full = bucket_cap();
			level_q = full[tbl_pkg::LEVEL_W-1:0];
		end
	endtask

	// every word sent and every result back: the block is idle
	// sampled mid-cycle so the driver and monitor have settled
	task automatic drain();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || due_responses.size() != 0);
	endtask

	// driver: takes words from the backlog in bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_responses.push_back(bucket_admit(in_word));
				n_words++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					in_word <= req_backlog.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each taken result against the oldest prediction
	always @(posedge clk) begin
		tbl_pkg::rsp_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_responses.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_MAX)
						$display("unexpected result word: granted %0b left %h wait %h",
							out_word.granted, out_word.tokens_left, out_word.wait_ticks);
				end else begin
					want = due_responses.pop_front();
					n_checked++;
					if (want.granted)
						n_grants++;
					if (want.wait_ticks != '0)
						n_waits++;
					if (out_word.granted !== want.granted
							|| out_word.tokens_left !== want.tokens_left
							|| out_word.wait_ticks !== want.wait_ticks) begin
						n_fail++;
						if (n_fail <= REPORT_MAX)
							$display("mismatch on result %0d: exp %0b/%h/%h got %0b/%h/%h",
								n_checked, want.granted, want.tokens_left, want.wait_ticks,
								out_word.granted, out_word.tokens_left, out_word.wait_ticks);
					end
				end
			end
			// receiver back-pressure for the next cycle
			stall_tick++;
			case (stall_style)
				STALL_NONE: out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
				STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
				STALL_LONG: begin
					if (stall_left != 0) begin
						stall_left--;
						out_stall <= 1'b1;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(4, 20);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				due_responses.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [tbl_pkg::RATE_W-1:0] rate_v;
		logic [tbl_pkg::DEPTH_W-1:0] depth_v;
		int unsigned depth_eff;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, one permit at one token per tick
		gap_max = 3;
		stall_style = STALL_RANDOM;
		queue_req(tbl_pkg::MODE_TRY, 16'd1, 16'd0);          // full bucket grants
		queue_req(tbl_pkg::MODE_TRY, 16'd1, 16'd0);          // empty, denied
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'd1, 16'd0);      // denied with wait
		queue_req(tbl_pkg::MODE_QUERY, 16'd0, 16'hFFFF);     // refill on query, capped
		queue_req(MODE_SPARE, 16'd1, 16'd0);                 // unused code acts as query
		queue_req(tbl_pkg::MODE_TRY, 16'd0, 16'd0);          // zero permits always granted
		queue_req(tbl_pkg::MODE_TRY, 16'hFFFF, 16'hFFFF);    // above the cap
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'hFFFF, 16'd0);   // above the cap, wait still given
		drain();
		n_phases++;

		// slowest rate, deepest bucket: largest possible wait
		write_reg(tbl_pkg::CFG_TOKEN_RATE, 32'd1);
		write_reg(tbl_pkg::CFG_BUCKET_DEPTH, 32'hFFFF);
		queue_req(tbl_pkg::MODE_TRY, 16'hFFFF, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'hFFFF, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'd1, 16'd3);
		queue_req(tbl_pkg::MODE_QUERY, 16'hFFFF, 16'hFFFF);
		drain();
		n_phases++;

		// fastest rate refills to the cap at once
		write_reg(tbl_pkg::CFG_TOKEN_RATE, 32'hFFFF_FFFF);
		queue_req(tbl_pkg::MODE_QUERY, 16'd0, 16'hFFFF);
		queue_req(tbl_pkg::MODE_TRY, 16'h8000, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'hFFFF, 16'd0);
		drain();
		n_phases++;

		// zero rate acts as one token per tick, zero depth as one permit
		write_reg(tbl_pkg::CFG_TOKEN_RATE, 32'd0);
		write_reg(tbl_pkg::CFG_BUCKET_DEPTH, 32'd0);
		queue_req(tbl_pkg::MODE_QUERY, 16'd0, 16'd0);
		queue_req(tbl_pkg::MODE_TRY, 16'd1, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'd1, 16'd0);
		queue_req(tbl_pkg::MODE_TRY, 16'd2, 16'hFFFF);
		drain();
		n_phases++;

		// a rate write alone keeps the level; half a token per tick
		write_reg(tbl_pkg::CFG_TOKEN_RATE, 32'h8000);
		queue_req(tbl_pkg::MODE_QUERY, 16'd0, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'd1, 16'd0);
		queue_req(tbl_pkg::MODE_ACQUIRE, 16'd1, 16'd1);
		queue_req(tbl_pkg::MODE_TRY, 16'd1, 16'd1);
		drain();
		n_phases++;

		// random phases, each with its own settings and idling
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: rate_v = $urandom_range(1, 32'hFFFF);
				1: rate_v = $urandom_range(32'h8000, 32'h40000);
				2: rate_v = $urandom;
				3: rate_v = $urandom_range(32'h10000, 32'h100000);
				4: begin
					case ($urandom_range(0, 2))
						0: rate_v = 32'd0;
						1: rate_v = 32'd1;
						default: rate_v = 32'hFFFF_FFFF;
					endcase
				end
				default: rate_v = $urandom_range(32'h100, 32'h20000);
			endcase
			case ($urandom_range(0, 7))
				0, 1, 2: depth_v = 16'($urandom_range(1, 16));
				3: depth_v = 16'($urandom);
				4: depth_v = 16'hFFFF;
				5: depth_v = 16'd0;
				default: depth_v = 16'($urandom_range(17, 512));
			endcase
			write_reg(tbl_pkg::CFG_TOKEN_RATE, rate_v);
			// some phases keep the depth, and with it the level left over
			if (ph % 3 != 2)
				write_reg(tbl_pkg::CFG_BUCKET_DEPTH, 32'(depth_v));
			depth_eff = (depth_q == '0) ? 1 : depth_q;
			if (ph % 4 == 0) begin
				gap_max = 0;
				stall_style = STALL_NONE;
			end else begin
				gap_max = $urandom_range(2, 40);
				stall_style = stall_style_t'($urandom_range(0, 3));
			end
			for (int k = 0; k < WORDS_PER_PHASE; k++)
				req_backlog.push_back(random_request(depth_eff));
			drain();
			n_phases++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_responses.size() != 0) begin
			n_fail++;
			$display("%0d results never arrived", due_responses.size());
		end
		$display("covered %0d request words over %0d setting phases with %0d register writes",
			n_words, n_phases, n_writes);
		$display("checked %0d results: %0d grants, %0d denials with wait, %0d failures",
			n_checked, n_grants, n_waits, n_fail);
		if (n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/tbl_pkg.sv
design/tbl_fifo.sv
design/tbl_front.sv
design/tbl_divider.sv
design/tbl_back.sv
design/token_bucket_limiter.sv
design/tbl_checker.sv
tb/tb.sv
